[design/rau_pkg.sv]
`timescale 1ns / 1ps
package rau_pkg;
   localparam int WIDTH_DEFAULT = 32;
   localparam int MAG_W = 64;
   localparam int CNT_W = 7;

   localparam logic [2:0] FUNC_MAKE = 3'd0;
   localparam logic [2:0] FUNC_ADD  = 3'd1;
   localparam logic [2:0] FUNC_SUB  = 3'd2;
   localparam logic [2:0] FUNC_MUL  = 3'd3;
   localparam logic [2:0] FUNC_DIV  = 3'd4;
   localparam logic [2:0] FUNC_CMP  = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ZERO  = 2'd1;
   localparam logic [1:0] ST_OVFL  = 2'd2;

   // classified item handed from front to back
   typedef struct packed {
      logic [1:0]  status;
      logic        is_cmp;
      logic        is_equal;
      logic        neg;
      logic [63:0] p_mag;
      logic [63:0] q_mag;
   } job_type;

   localparam int JOB_W = $bits(job_type);
endpackage

[design/rational_arithmetic_unit.sv]
`timescale 1ns / 1ps
// Path: front (normalize, cross products, classify), two-entry queue, then a back
// end with binary-GCD steps, two quotient passes and a range check; an error or
// compare item goes from the back end's idle state straight to its output.
// Flow: the back end holds one item at a time and sets the rate; the front takes
// a new item only after its last one has gone into the queue.
// Reset: synchronous, active high; clears all control state and the queue.
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_num[31:0], a_den[63:32], b_num[95:64], b_den[126:96], zero pad
   input  logic [127:0] req_tdata,
   // func[2:0]
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // res_num[31:0], res_den[62:32], is_equal[63], status[65:64], zero pad
   output logic [71:0]  rsp_tdata
);
   logic    fj_valid, fj_ready, bj_valid, bj_ready;
   job_type fj, bj;
   logic [31:0] res_num;
   logic [30:0] res_den;
   logic        is_equal;
   logic [1:0]  status;

   rau_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .func(req_tuser), .a_num(req_tdata[31:0]), .a_den(req_tdata[63:32]),
      .b_num(req_tdata[95:64]), .b_den(req_tdata[126:96]),
      .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
   );

   rau_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
      .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
   );

   rau_back #(.WIDTH(WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .res_num(res_num), .res_den(res_den), .is_equal(is_equal), .status(status)
   );

   assign rsp_tdata = {6'd0, status, is_equal, res_den, res_num};
endmodule

[design/rau_front.sv]
`timescale 1ns / 1ps
// Front: normalize operands, form cross products in a registered state, classify.
module rau_front
   import rau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [2:0]  func,
   input  logic [31:0] a_num,
   input  logic [31:0] a_den,
   input  logic [31:0] b_num,
   input  logic [30:0] b_den,
   output logic        job_valid,
   input  logic        job_ready,
   output job_type     job
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  func_ff;
   logic        an_neg_ff, bn_neg_ff, bad_ff;
   logic [31:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [63:0] m1_ff, m2_ff, m3_ff;
   job_type     job_ff, job_in;

   logic        an_s, ad_s, bn_s;
   logic [31:0] an_m, ad_m, bn_m;
   logic        an_n, bn_n;

   // split inputs into sign and magnitude
   always_comb begin
      an_s = a_num[31]; ad_s = a_den[31]; bn_s = b_num[31];
      an_m = an_s ? 32'(-a_num) : a_num;
      ad_m = ad_s ? 32'(-a_den) : a_den;
      bn_m = bn_s ? 32'(-b_num) : b_num;
      an_n = (an_s ^ ad_s) && (an_m != 32'd0);
      bn_n = bn_s && (bn_m != 32'd0);
      if (func == FUNC_SUB && bn_m != 32'd0) bn_n = ~bn_n;
   end

   assign in_ready  = (state_ff == S_IDLE);
   assign job_valid = (state_ff == S_OUT);
   assign job       = job_ff;

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         func_ff <= func;
         an_ff <= an_m; ad_ff <= ad_m; bn_ff <= bn_m; bd_ff <= {1'b0, b_den};
         an_neg_ff <= an_n; bn_neg_ff <= bn_n;
         bad_ff <= (func > FUNC_CMP) || (ad_m == 32'd0) ||
                   (func != FUNC_MAKE && b_den == 31'd0) ||
                   (func == FUNC_DIV && bn_m == 32'd0);
      end
      // one 32x32 product per register; multiply needs a_num*b_num in place of a_num*b_den
      if (state_ff == S_MUL) begin
         m1_ff <= (func_ff == FUNC_MUL) ? 64'(an_ff) * 64'(bn_ff)
                                        : 64'(an_ff) * 64'(bd_ff);
         m2_ff <= 64'(ad_ff) * 64'(bn_ff);
         m3_ff <= 64'(ad_ff) * 64'(bd_ff);
      end
      if (state_ff == S_FIN) job_ff <= job_in;
   end

   logic l_neg, r_neg;
   // combine products and classify
   always_comb begin
      job_in = '0;
      l_neg = an_neg_ff && m1_ff != 64'd0;
      r_neg = bn_neg_ff && m2_ff != 64'd0;
      unique case (func_ff)
         FUNC_MAKE: begin
            job_in.p_mag = 64'(an_ff); job_in.q_mag = 64'(ad_ff);
            job_in.neg = an_neg_ff;
         end
         FUNC_ADD, FUNC_SUB: begin
            job_in.q_mag = m3_ff;
            if (l_neg == r_neg) begin
               job_in.p_mag = m1_ff + m2_ff; job_in.neg = l_neg;
            end else if (m1_ff >= m2_ff) begin
               job_in.p_mag = m1_ff - m2_ff; job_in.neg = l_neg;
            end else begin
               job_in.p_mag = m2_ff - m1_ff; job_in.neg = r_neg;
            end
         end
         FUNC_MUL: begin
            job_in.p_mag = m1_ff; job_in.q_mag = m3_ff;
            job_in.neg = an_neg_ff ^ bn_neg_ff;
         end
         FUNC_DIV: begin
            job_in.p_mag = m1_ff; job_in.q_mag = m2_ff;
            job_in.neg = an_neg_ff ^ bn_neg_ff;
         end
         default: begin
            job_in.is_cmp = 1'b1;
            job_in.is_equal = (m1_ff == m2_ff) && (l_neg == r_neg);
         end
      endcase
      if (job_in.p_mag == 64'd0) job_in.neg = 1'b0;
      if (bad_ff) job_in = '{status: ST_ZERO, default: '0};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (in_valid) state_in = S_MUL;
         S_MUL:   state_in = S_FIN;
         S_FIN:   state_in = S_OUT;
         default: if (job_ready) state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end
endmodule

[design/rau_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue between front and back.
module rau_queue
   import rau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_ready,
   input  job_type wr_data,
   output logic    rd_valid,
   input  logic    rd_ready,
   output job_type rd_data
);
   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr, rd;

   assign wr_ready = (cnt_ff != 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
   end
endmodule

[design/rau_back.sv]
`timescale 1ns / 1ps
// Back: binary GCD, two restoring divisions, range check, output register.
module rau_back
   import rau_pkg::*;
#(
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   output logic        job_ready,
   input  job_type     job,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [31:0] res_num,
   output logic [30:0] res_den,
   output logic        is_equal,
   output logic [1:0]  status
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_GCD  = 3'd1;
   localparam logic [2:0] S_DIVP = 3'd2;
   localparam logic [2:0] S_DIVQ = 3'd3;
   localparam logic [2:0] S_CHK  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;
   localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

   logic [2:0]  state_ff;
   logic        neg_ff;
   logic [63:0] p_ff, q_ff, x_ff, y_ff, g_ff;
   logic [CNT_W-1:0] sh_ff, cnt_ff;
   logic [63:0] quo_ff, rem_ff;
   logic [31:0] num_ff;
   logic [30:0] den_ff;
   logic        eq_ff;
   logic [1:0]  st_ff;

   logic [64:0] rem_sh;
   logic [63:0] dvd;
   assign dvd    = (state_ff == S_DIVP) ? p_ff : q_ff;
   assign rem_sh = {rem_ff, dvd[cnt_ff[5:0]]};

   assign job_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT);
   assign res_num = num_ff; assign res_den = den_ff;
   assign is_equal = eq_ff; assign status = st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: if (job_valid) begin
               p_ff <= job.p_mag; q_ff <= job.q_mag; neg_ff <= job.neg;
               x_ff <= job.p_mag; y_ff <= job.q_mag; sh_ff <= '0;
               num_ff <= '0; den_ff <= '0; eq_ff <= job.is_equal;
               st_ff <= job.status;
               state_ff <= (job.status != ST_OK || job.is_cmp) ? S_OUT : S_GCD;
            end
            // binary gcd: one step a cycle
            S_GCD: begin
               if (x_ff == 64'd0 || y_ff == 64'd0) begin
                  g_ff <= ((x_ff | y_ff) == 64'd0) ? 64'd1 : ((x_ff | y_ff) << sh_ff);
                  cnt_ff <= CNT_W'(63); rem_ff <= '0; quo_ff <= '0;
                  state_ff <= S_DIVP;
               end else if (!x_ff[0] && !y_ff[0]) begin
                  x_ff <= x_ff >> 1; y_ff <= y_ff >> 1; sh_ff <= sh_ff + 1'b1;
               end else if (!x_ff[0]) begin
                  x_ff <= x_ff >> 1;
               end else if (!y_ff[0]) begin
                  y_ff <= y_ff >> 1;
               end else if (x_ff >= y_ff) begin
                  x_ff <= (x_ff - y_ff) >> 1;
               end else begin
                  y_ff <= (y_ff - x_ff) >> 1;
               end
            end
            // restoring division, one quotient bit a cycle
            S_DIVP, S_DIVQ: begin
               quo_ff <= {quo_ff[62:0], rem_sh >= {1'b0, g_ff}};
               if (cnt_ff == '0) begin
                  rem_ff <= '0; cnt_ff <= CNT_W'(63);
                  if (state_ff == S_DIVP) begin
                     p_ff <= {quo_ff[62:0], rem_sh >= {1'b0, g_ff}};
                     state_ff <= S_DIVQ;
                  end else begin
                     q_ff <= {quo_ff[62:0], rem_sh >= {1'b0, g_ff}};
                     state_ff <= S_CHK;
                  end
               end else begin
                  if (rem_sh >= {1'b0, g_ff}) begin
                     rem_ff <= 64'(rem_sh - {1'b0, g_ff});
                  end else begin
                     rem_ff <= rem_sh[63:0];
                  end
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            S_CHK: begin
               if (q_ff > LIM - 64'd1 ||
                   (neg_ff ? p_ff > LIM : p_ff > LIM - 64'd1)) begin
                  st_ff <= ST_OVFL;
               end else begin
                  num_ff <= neg_ff ? 32'(-p_ff) : p_ff[31:0];
                  den_ff <= q_ff[30:0];
               end
               state_ff <= S_OUT;
            end
            default: if (out_ready) state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb
   import rau_pkg::*;
();

   localparam int WIDTH = 32;
   localparam int LIMIT_CYCLES = 1500000;
   localparam int RANDOM_ITEMS = 1100;

   // packed to match rsp_tdata: num in the lowest bits
   typedef struct packed {
      logic [1:0]  status;
      logic        is_equal;
      logic [30:0] den;
      logic [31:0] num;
   } fraction_result_type;

   typedef struct {
      logic [2:0]  func;
      logic [31:0] a_num;
      logic [31:0] a_den;
      logic [31:0] b_num;
      logic [30:0] b_den;
      logic        known;
      logic [31:0] r_num;
      logic [30:0] r_den;
      logic        r_eq;
      logic [1:0]  r_st;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;

   fraction_result_type expected_results[$];
   int  error_count = 0;
   int  cycle_count = 0;
   bit  quiet_stretch = 1'b0;

   rational_arithmetic_unit #(.WIDTH(WIDTH)) u_top (.*);

   always #5 clock = ~clock;

   // magnitude of a 32-bit two's complement value, widened to 64 bits
   function automatic logic [63:0] mag_of(input logic [31:0] v);
      return v[31] ? {32'd0, -v} : {32'd0, v};
   endfunction

   function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = y;
         y = x % y;
         x = t;
      end
      return x;
   endfunction

   // signed add on sign/magnitude pairs
   function automatic void sm_add(input logic xn, input logic [63:0] xm,
                                  input logic yn, input logic [63:0] ym,
                                  output logic rn, output logic [63:0] rm);
      if (xn == yn) begin
         rn = xn;
         rm = xm + ym;
      end else if (xm >= ym) begin
         rn = xn;
         rm = xm - ym;
      end else begin
         rn = yn;
         rm = ym - xm;
      end
      if (rm == 0) rn = 1'b0;
   endfunction

   // compute the reduced fraction for one item
   function automatic fraction_result_type reduce_fraction(input logic [2:0] func,
         input logic [31:0] a_num, input logic [31:0] a_den,
         input logic [31:0] b_num, input logic [30:0] b_den);
      fraction_result_type r;
      logic an_n, ad_n, bn_n, p_n, l_n, r_n;
      logic [63:0] an_m, ad_m, bn_m, bd_m, p_m, q_m, l_m, r_m, g, lim;
      r = '0;
      an_n = a_num[31]; an_m = mag_of(a_num);
      ad_n = a_den[31]; ad_m = mag_of(a_den);
      bn_n = b_num[31]; bn_m = mag_of(b_num);
      bd_m = {33'd0, b_den};
      if (func > FUNC_CMP || ad_m == 0 || (func != FUNC_MAKE && bd_m == 0)) begin
         r.status = ST_ZERO;
         return r;
      end
      if (ad_n) begin
         an_n = !an_n && an_m != 0;
      end
      if (an_m == 0) an_n = 1'b0;
      if (bn_m == 0) bn_n = 1'b0;
      p_n = 1'b0; p_m = 0; q_m = 0;
      case (func)
         FUNC_MAKE: begin
            p_n = an_n; p_m = an_m; q_m = ad_m;
         end
         FUNC_ADD, FUNC_SUB: begin
            if (func == FUNC_SUB && bn_m != 0) bn_n = !bn_n;
            l_m = an_m * bd_m; l_n = an_n && l_m != 0;
            r_m = ad_m * bn_m; r_n = bn_n && r_m != 0;
            sm_add(l_n, l_m, r_n, r_m, p_n, p_m);
            q_m = ad_m * bd_m;
         end
         FUNC_MUL: begin
            p_m = an_m * bn_m; p_n = (an_n != bn_n) && p_m != 0;
            q_m = ad_m * bd_m;
         end
         FUNC_DIV: begin
            if (bn_m == 0) begin
               r.status = ST_ZERO;
               return r;
            end
            p_m = an_m * bd_m; p_n = an_n && p_m != 0;
            q_m = ad_m * bn_m;
            if (bn_n) p_n = !p_n && p_m != 0;
         end
         default: begin
            l_m = an_m * bd_m; l_n = an_n && l_m != 0;
            r_m = ad_m * bn_m; r_n = bn_n && r_m != 0;
            r.is_equal = (l_m == r_m) && (l_n == r_n);
            return r;
         end
      endcase
      g = gcd64(p_m, q_m);
      if (g == 0) g = 1;
      p_m = p_m / g;
      q_m = q_m / g;
      if (p_m == 0) p_n = 1'b0;
      lim = 64'd1 << (WIDTH - 1);
      if (q_m > lim - 1 || (p_n ? p_m > lim : p_m > lim - 1)) begin
         r.status = ST_OVFL;
         return r;
      end
      r.num = p_n ? 32'(-p_m) : 32'(p_m);
      r.den = 31'(q_m);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // offer one item and hold it until accepted
   task automatic send_item(input logic [2:0] func, input logic [31:0] a_num,
                            input logic [31:0] a_den, input logic [31:0] b_num,
                            input logic [30:0] b_den, input fraction_result_type want);
      while (!quiet_stretch && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {1'b0, b_den, b_num, a_den, a_num};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(want);
   endtask

   function automatic logic [31:0] rand_word(input int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(200)) - 100);
         2: return $urandom_range(65535);
         default: return 32'($signed(-$urandom_range(65535)));
      endcase
   endfunction

   // random stall on the result side, with a quiet stretch in the middle
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_tready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= 6);
   end

   // check each accepted item against the oldest expectation
   always @(posedge clock) begin
      fraction_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[65:0];
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected item", 64'(got), 64'd0);
         end else begin
            want = expected_results.pop_front();
            if (got.num != want.num)
               report_mismatch("res_num", 64'(got.num), 64'(want.num));
            if (got.den != want.den)
               report_mismatch("res_den", 64'(got.den), 64'(want.den));
            if (got.is_equal != want.is_equal)
               report_mismatch("is_equal", 64'(got.is_equal), 64'(want.is_equal));
            if (got.status != want.status)
               report_mismatch("status", 64'(got.status), 64'(want.status));
         end
      end
   end

   // end the run on a hung block
   always @(posedge clock) begin
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      fraction_result_type want;
      logic [2:0]  func;
      logic [31:0] a_num, a_den, b_num;
      logic [30:0] b_den;
      int pick;
      // directed rows: known answers where obvious, else predicted
      rows = '{
         '{FUNC_MAKE, 32'd6, 32'hFFFF_FFFC, 32'd0, 31'd0, 1, 32'hFFFF_FFFD, 31'd2, 0, ST_OK},
         '{FUNC_MAKE, 32'd0, 32'd7, 32'd5, 31'd3, 1, 32'd0, 31'd1, 0, ST_OK},
         '{FUNC_MAKE, 32'd1, 32'd0, 32'd0, 31'd1, 1, 32'd0, 31'd0, 0, ST_ZERO},
         '{FUNC_ADD, 32'd1, 32'd2, 32'd1, 31'd0, 1, 32'd0, 31'd0, 0, ST_ZERO},
         '{FUNC_DIV, 32'd1, 32'd2, 32'd0, 31'd3, 1, 32'd0, 31'd0, 0, ST_ZERO},
         '{3'd6, 32'd1, 32'd2, 32'd1, 31'd3, 1, 32'd0, 31'd0, 0, ST_ZERO},
         '{3'd7, 32'd1, 32'd2, 32'd1, 31'd3, 1, 32'd0, 31'd0, 0, ST_ZERO},
         '{FUNC_MAKE, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 31'd1, 1, 32'd0, 31'd0, 0, ST_OVFL},
         '{FUNC_MAKE, 32'h8000_0000, 32'd1, 32'd0, 31'd1, 1, 32'h8000_0000, 31'd1, 0, ST_OK},
         '{FUNC_MAKE, 32'd1, 32'h8000_0000, 32'd0, 31'd1, 1, 32'd0, 31'd0, 0, ST_OVFL},
         '{FUNC_CMP, 32'd1, 32'd2, 32'd2, 31'd4, 1, 32'd0, 31'd0, 1, ST_OK},
         '{FUNC_CMP, 32'd1, 32'd2, 32'hFFFF_FFFF, 31'd2, 1, 32'd0, 31'd0, 0, ST_OK},
         '{FUNC_ADD, 32'd1, 32'd2, 32'd1, 31'd3, 0, 0, 0, 0, 0},
         '{FUNC_SUB, 32'd1, 32'd2, 32'd1, 31'd2, 0, 0, 0, 0, 0},
         '{FUNC_SUB, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0, 0, 0},
         '{FUNC_MUL, 32'h7FFF_FFFF, 32'd3, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0, 0, 0},
         '{FUNC_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'd1, 0, 0, 0, 0, 0},
         '{FUNC_DIV, 32'd3, 32'd4, 32'hFFFF_FFFA, 31'd8, 0, 0, 0, 0, 0},
         '{FUNC_DIV, 32'h7FFF_FFFF, 32'd1, 32'd1, 31'h7FFF_FFFF, 0, 0, 0, 0, 0},
         '{FUNC_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFE, 0, 0, 0, 0, 0},
         '{FUNC_CMP, 32'h8000_0000, 32'h8000_0000, 32'd1, 31'd1, 0, 0, 0, 0, 0},
         '{FUNC_MAKE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 31'd0, 0, 0, 0, 0, 0}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // walk the directed table
      foreach (rows[i]) begin
         row = rows[i];
         if (row.known) begin
            want = '{num: row.r_num, den: row.r_den, is_equal: row.r_eq,
                     status: row.r_st};
         end else begin
            want = reduce_fraction(row.func, row.a_num, row.a_den, row.b_num, row.b_den);
         end
         send_item(row.func, row.a_num, row.a_den, row.b_num, row.b_den, want);
      end
      // random items: mostly valid operands, some malformed
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet_stretch = (n >= 400 && n < 550);
         pick  = $urandom_range(99);
         func  = (pick < 4) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
         a_num = rand_word($urandom_range(3));
         a_den = rand_word($urandom_range(3));
         b_num = rand_word($urandom_range(3));
         b_den = 31'(rand_word($urandom_range(2)));
         if (pick >= 10) begin
            if (a_den == 0) a_den = 1;
            if (b_den == 0) b_den = 1;
            if (func != FUNC_MAKE && a_den[31]) a_den = -a_den;
            if (a_den[31]) a_den = 32'h7FFF_FFFF;
         end
         want = reduce_fraction(func, a_num, a_den, b_num, b_den);
         send_item(func, a_num, a_den, b_num, b_den, want);
      end
      req_tvalid <= 1'b0;
      quiet_stretch = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
